[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[hw/rtl/oac_pkg.sv]
// Package: constants and types of the overdrive chain
`timescale 1ns / 1ps
package oac_pkg;
	localparam int SampleWidthDef = 24;
	localparam int WordW = 32;
	localparam int CfgW = 24;
	localparam int IdxW = 3;
	localparam int SerW = 64;
	localparam int MulW = 32;
	localparam int CntW = 6;

	typedef enum logic [IdxW-1:0] {
		REG_HP_IN = 3'd0, REG_LP_IN = 3'd1, REG_HP_MID = 3'd2,
		REG_LP_OUT = 3'd3, REG_DRIVE = 3'd4, REG_LEVEL = 3'd5
	} reg_idx_t;

	// Request to the serial multiplier
	typedef struct packed {
		logic                   start;
		logic signed [SerW-1:0] mcand;
		logic [MulW-1:0]        mplier;
	} mul_req_t;

	function automatic logic signed [WordW-1:0] sat32(input logic signed [SerW-1:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[WordW-1:0];
	endfunction
endpackage

[hw/rtl/oac_stream_if.sv]
// Valid/ready stream channel
`timescale 1ns / 1ps
interface oac_stream_if #(parameter int W = oac_pkg::SampleWidthDef);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[hw/rtl/oac_serial_mul.sv]
// Shift-and-add multiplier: one multiplier bit per cycle
`timescale 1ns / 1ps
`include "assert_macros.svh"
module oac_serial_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  oac_pkg::mul_req_t             req,
	output logic                          done,
	output logic signed [oac_pkg::SerW-1:0] product
);
	localparam int CW = oac_pkg::CntW;

	logic signed [oac_pkg::SerW-1:0] acc_q, mc_q;
	logic [oac_pkg::MulW-1:0] mp_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(oac_pkg::MulW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// add when the low multiplier bit is set, then double the multiplicand and advance one bit
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			mc_q  <= req.mcand;
			mp_q  <= req.mplier;
		end else if (busy_q) begin
			if (mp_q[0]) acc_q <= acc_q + mc_q;
			mc_q <= mc_q <<< 1;
			mp_q <= mp_q >> 1;
		end
	end
	assign product = acc_q;

	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	`ASSERT_IMP(a_no_restart, clk, arst_n, busy_q, !req.start)
endmodule

[hw/rtl/oac_core.sv]
// Sequencer of the filter and shaping chain around one serial multiplier
`timescale 1ns / 1ps
`include "assert_macros.svh"
module oac_core #(
	parameter int SAMPLE_WIDTH = oac_pkg::SampleWidthDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [oac_pkg::IdxW-1:0]    cfg_index,
	input  logic [oac_pkg::CfgW-1:0]    cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [SAMPLE_WIDTH-1:0]     in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [SAMPLE_WIDTH-1:0]     out_data
);
	localparam int W = oac_pkg::WordW;
	localparam int S = oac_pkg::SerW;
	localparam int M = oac_pkg::MulW;
	// sample format sits 25 - SAMPLE_WIDTH bits below the internal Q8.24
	localparam int ShUp = (SAMPLE_WIDTH <= 25) ? 25 - SAMPLE_WIDTH : 0;
	localparam int ShDn = (SAMPLE_WIDTH > 25) ? SAMPLE_WIDTH - 25 : 0;
	localparam logic signed [S-1:0] One = 64'sd16777216;
	localparam logic signed [S-1:0] SMax = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
	localparam logic signed [S-1:0] SMin = -SMax - 64'sd1;
	localparam logic signed [W-1:0] NegQuarter = -32'sd4194304;
	localparam logic signed [W-1:0] NegOne = -32'sd16777216;
	localparam logic signed [W-1:0] PosOne = 32'sd16777216;
	localparam logic [16:0] HpBase = 17'd65536;

	typedef enum logic [4:0] {
		ST_IDLE, ST_HP1A, ST_HP1B, ST_LP1, ST_GAIN, ST_SQ1GO, ST_SQ1, ST_HP2GO,
		ST_HP2A, ST_HP2B, ST_DRV, ST_SQ2GO, ST_SQ2, ST_LP2GO, ST_LP2, ST_LVL,
		ST_CONV, ST_OUT
	} state_t;

	state_t state_q;
	logic [15:0] hp_in_q, lp_in_q, hp_mid_q, lp_out_q;
	logic [23:0] drive_q;
	logic [16:0] level_q;
	logic signed [W-1:0] x_q, hp1_x_q, hp1_y_q, lp1_y_q, hp2_x_q, hp2_y_q, lp2_y_q;
	logic signed [S-1:0] part_q;
	logic [SAMPLE_WIDTH-1:0] out_q;
	oac_pkg::mul_req_t req_q;
	logic mdone;
	logic signed [S-1:0] prod;
	logic signed [S-1:0] xin, x_abs, o, mc_d;
	logic [M-1:0] mp_d;
	logic issue;
	logic signed [W-1:0] x_in, hp_y, lp_y, shaped, clipped;

	oac_serial_mul u_mul (.clk, .arst_n, .req(req_q), .done(mdone), .product(prod));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_in_q <= 16'd63000; lp_in_q <= 16'd39000; hp_mid_q <= 16'd65400;
			lp_out_q <= 16'd50000; drive_q <= 24'd65536; level_q <= 17'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				oac_pkg::REG_HP_IN:  hp_in_q  <= cfg_data[15:0];
				oac_pkg::REG_LP_IN:  lp_in_q  <= cfg_data[15:0];
				oac_pkg::REG_HP_MID: hp_mid_q <= cfg_data[15:0];
				oac_pkg::REG_LP_OUT: lp_out_q <= cfg_data[15:0];
				oac_pkg::REG_DRIVE:  drive_q  <= cfg_data;
				oac_pkg::REG_LEVEL:  level_q  <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		xin = (S'($signed(in_data)) <<< ShUp) >>> ShDn;
		x_in = oac_pkg::sat32(xin);
		hp_y = oac_pkg::sat32((part_q + prod) >>> 17);
		lp_y = oac_pkg::sat32(S'(x_q) + (prod >>> 16));
		x_abs = x_q[W-1] ? -S'(x_q) : S'(x_q);
		// flat below minus one half, x*x + x elsewhere
		if (S'(x_q) < -(One >>> 1)) shaped = NegQuarter;
		else shaped = oac_pkg::sat32((prod >>> 24) + S'(x_q));
		if (S'(x_q) < -One) clipped = NegOne;
		else if (x_q < 0) clipped = oac_pkg::sat32((prod >>> 24) + (S'(x_q) <<< 1));
		else if (S'(x_q) < One) clipped = oac_pkg::sat32((S'(x_q) <<< 1) - (prod >>> 24));
		else clipped = PosOne;
		o = (S'(x_q) >>> ShUp) <<< ShDn;
	end

	// operands of the next multiply
	always_comb begin
		issue = 1'b0;
		mc_d = '0;
		mp_d = '0;
		case (state_q)
			ST_IDLE: begin
				issue = in_valid;
				mc_d = S'(x_in) - S'(hp1_x_q);
				mp_d = M'(HpBase + 17'(hp_in_q));
			end
			ST_HP1A: begin
				issue = mdone;
				mc_d = S'(hp1_y_q) <<< 1;
				mp_d = M'(hp_in_q);
			end
			ST_HP1B: begin
				issue = mdone;
				mc_d = S'(lp1_y_q) - S'(hp_y);
				mp_d = M'(lp_in_q);
			end
			ST_SQ1GO, ST_SQ2GO: begin
				issue = 1'b1;
				mc_d = x_abs;
				mp_d = x_abs[M-1:0];
			end
			ST_HP2GO: begin
				issue = 1'b1;
				mc_d = S'(x_q) - S'(hp2_x_q);
				mp_d = M'(HpBase + 17'(hp_mid_q));
			end
			ST_HP2A: begin
				issue = mdone;
				mc_d = S'(hp2_y_q) <<< 1;
				mp_d = M'(hp_mid_q);
			end
			ST_HP2B: begin
				issue = mdone;
				mc_d = S'(hp_y);
				mp_d = M'(drive_q);
			end
			ST_LP2GO: begin
				issue = 1'b1;
				mc_d = S'(lp2_y_q) - S'(x_q);
				mp_d = M'(lp_out_q);
			end
			ST_LP2: begin
				issue = mdone;
				mc_d = S'(lp_y);
				mp_d = M'(level_q);
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; req_q <= '0; part_q <= '0; x_q <= '0; out_q <= '0;
			hp1_x_q <= '0; hp1_y_q <= '0; lp1_y_q <= '0;
			hp2_x_q <= '0; hp2_y_q <= '0; lp2_y_q <= '0;
		end else begin
			req_q.start <= issue;
			if (issue) begin
				req_q.mcand <= mc_d;
				req_q.mplier <= mp_d;
			end
			case (state_q)
				ST_IDLE: if (in_valid) begin
					x_q <= x_in;
					state_q <= ST_HP1A;
				end
				ST_HP1A: if (mdone) begin
					part_q <= prod;
					state_q <= ST_HP1B;
				end
				ST_HP1B: if (mdone) begin
					hp1_x_q <= x_q;
					hp1_y_q <= hp_y;
					x_q <= hp_y;
					state_q <= ST_LP1;
				end
				ST_LP1: if (mdone) begin
					lp1_y_q <= lp_y;
					x_q <= lp_y;
					state_q <= ST_GAIN;
				end
				// gain of five as a shift and an add
				ST_GAIN: begin
					x_q <= oac_pkg::sat32((S'(x_q) <<< 2) + S'(x_q));
					state_q <= ST_SQ1GO;
				end
				ST_SQ1GO: state_q <= ST_SQ1;
				ST_SQ1: if (mdone) begin
					x_q <= shaped;
					state_q <= ST_HP2GO;
				end
				ST_HP2GO: state_q <= ST_HP2A;
				ST_HP2A: if (mdone) begin
					part_q <= prod;
					state_q <= ST_HP2B;
				end
				ST_HP2B: if (mdone) begin
					hp2_x_q <= x_q;
					hp2_y_q <= hp_y;
					state_q <= ST_DRV;
				end
				ST_DRV: if (mdone) begin
					x_q <= oac_pkg::sat32(prod >>> 16);
					state_q <= ST_SQ2GO;
				end
				ST_SQ2GO: state_q <= ST_SQ2;
				ST_SQ2: if (mdone) begin
					x_q <= clipped;
					state_q <= ST_LP2GO;
				end
				ST_LP2GO: state_q <= ST_LP2;
				ST_LP2: if (mdone) begin
					lp2_y_q <= lp_y;
					state_q <= ST_LVL;
				end
				ST_LVL: if (mdone) begin
					x_q <= oac_pkg::sat32(prod >>> 16);
					state_q <= ST_CONV;
				end
				ST_CONV: begin
					if (o > SMax) out_q <= SMax[SAMPLE_WIDTH-1:0];
					else if (o < SMin) out_q <= SMin[SAMPLE_WIDTH-1:0];
					else out_q <= o[SAMPLE_WIDTH-1:0];
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_IMP(a_out_holds_input, clk, arst_n, out_valid, !in_ready)
	`ASSERT_NEXT(a_accept_starts, clk, arst_n, in_valid && in_ready, state_q == ST_HP1A && req_q.start)
	`ASSERT_NEXT(a_out_held, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

[hw/rtl/overdrive_audio_chain.sv]
// Top level of the quadratic overdrive chain
// An accepted input item runs through ten passes of the 32-bit serial multiplier
// and six further states: gain, four multiplier issue states and output conversion.
// A new item is accepted only after the result has been taken at the output.
// Reset: arst_n clears filter state and loads the register defaults at once.
`timescale 1ns / 1ps
module overdrive_audio_chain #(
	parameter int SAMPLE_WIDTH = oac_pkg::SampleWidthDef
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [oac_pkg::IdxW-1:0] cfg_index,
	input  logic [oac_pkg::CfgW-1:0] cfg_data,
	oac_stream_if.sink               sample_in,
	oac_stream_if.source             sample_out
);
	oac_core #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_core (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid(sample_in.valid), .in_ready(sample_in.ready), .in_data(sample_in.data),
		.out_valid(sample_out.valid), .out_ready(sample_out.ready),
		.out_data(sample_out.data)
	);
endmodule
